/* src/sdmsh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmsh_pkg - shared definitions for the Speck Davies-Meyer string hash
// Constants, rotate helper and the controller/datapath command and status
// structs.
// ----------------------------------------------------------------------------
package sdmsh_pkg;

    // Block and cipher geometry
    localparam int BLOCK_BYTES          = 16;
    localparam int FILL_W               = $clog2(BLOCK_BYTES);
    localparam int LEN_OFFSET           = BLOCK_BYTES - 4;
    localparam int SPECK_ROUNDS         = 27;
    localparam int RND_W                = $clog2(SPECK_ROUNDS);
    localparam int ROT_A                = 8;
    localparam int ROT_B                = 29;
    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam int DEF_MAX_STRING_BYTES = 64;

    // Configuration register map (8-byte stride)
    localparam int PADDR_W              = 4;
    localparam logic REG_IV             = 1'b0;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // input item taken this cycle
        logic run_load;   // load cipher state and key from buffer
        logic run_round;  // one Speck round
        logic pad2;       // second padding block: zeros plus length
        logic emit;       // copy chaining value to output, rearm
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic terminate;  // current item ends the string
        logic fill_high;  // pad byte lands in the length word
        logic fill_last;  // current item completes a block
        logic round_last; // final round in progress
    } t_dp_status;

    // 32-bit rotate right by a constant amount
    function automatic logic [31:0] rotr32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

/* src/sdmsh_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmsh_ctrl - hash controller
// Sequences byte intake, block compression, the optional second padding
// block and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module sdmsh_ctrl
    import sdmsh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_PAD2  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_term, n_term;
    logic       r_second, n_second;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    // Output register can take a new result
    assign out_free = !r_out_valid || !i_stall;

    // Commands
    assign o_cmd.accept    = (r_state == S_IDLE) && i_valid;
    assign o_cmd.run_load  = (r_state == S_LOAD);
    assign o_cmd.run_round = (r_state == S_ROUND);
    assign o_cmd.pad2      = (r_state == S_PAD2);
    assign o_cmd.emit      = (r_state == S_EMIT) && out_free;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state  = r_state;
        n_term   = r_term;
        n_second = r_second;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_sts.terminate) begin
                        n_term   = 1'b1;
                        n_second = i_sts.fill_high;
                        n_state  = S_LOAD;
                    end else if (i_sts.fill_last) begin
                        n_term  = 1'b0;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: n_state = S_ROUND;
            S_ROUND: begin
                if (i_sts.round_last) begin
                    if (r_second) begin
                        n_second = 1'b0;
                        n_state  = S_PAD2;
                    end else if (r_term) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PAD2: n_state = S_LOAD;
            S_EMIT: begin
                if (out_free) begin
                    n_term  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_term      <= 1'b0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_term      <= n_term;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* src/sdmsh_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmsh_dp - hash datapath
// Block buffer, byte counters, chaining value, one Speck-64/128 round unit
// with its key schedule, and the result register.
// ----------------------------------------------------------------------------
module sdmsh_dp
    import sdmsh_pkg::*;
#(
    parameter int MAX_STRING_BYTES = DEF_MAX_STRING_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_sts,
    input  logic [7:0]  i_data_byte,
    input  logic [63:0] i_iv,
    output logic [63:0] o_hash_value
);

    localparam int CNT_W = $clog2(MAX_STRING_BYTES + 1);

    logic [7:0]        r_buf [BLOCK_BYTES];
    logic [7:0]        n_buf [BLOCK_BYTES];
    logic [FILL_W-1:0] r_fill;
    logic [CNT_W-1:0]  r_count;
    logic [63:0]       r_chain;
    logic [63:0]       r_hash;
    logic [31:0]       r_a, r_b;
    logic [31:0]       r_k [4];
    logic [RND_W-1:0]  r_round;
    logic [31:0]       n_a, n_b, n_k3, n_k0;
    logic [31:0]       len_word;

    // Status
    assign o_sts.terminate  = (i_data_byte == 8'd0) ||
                              (r_count >= CNT_W'(MAX_STRING_BYTES));
    assign o_sts.fill_high  = (r_fill >= FILL_W'(LEN_OFFSET));
    assign o_sts.fill_last  = (r_fill == FILL_W'(BLOCK_BYTES - 1));
    assign o_sts.round_last = (r_round == RND_W'(SPECK_ROUNDS - 1));

    // Bit length of the string
    assign len_word = 32'({r_count, 3'b000});

    // Next buffer contents
    always_comb begin
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            n_buf[i] = r_buf[i];
        end
        if (i_cmd.accept) begin
            if (o_sts.terminate) begin
                // pad byte, zeros after it, length if it still fits
                for (int i = 0; i < BLOCK_BYTES; i++) begin
                    if (FILL_W'(i) == r_fill) begin
                        n_buf[i] = PAD_BYTE;
                    end else if (FILL_W'(i) > r_fill) begin
                        n_buf[i] = 8'd0;
                    end
                end
                if (!o_sts.fill_high) begin
                    for (int j = 0; j < 4; j++) begin
                        n_buf[LEN_OFFSET + j] = len_word[8*j +: 8];
                    end
                end
            end else begin
                for (int i = 0; i < BLOCK_BYTES; i++) begin
                    if (FILL_W'(i) == r_fill) begin
                        n_buf[i] = i_data_byte;
                    end
                end
            end
        end else if (i_cmd.pad2) begin
            for (int i = 0; i < BLOCK_BYTES; i++) begin
                n_buf[i] = 8'd0;
            end
            for (int j = 0; j < 4; j++) begin
                n_buf[LEN_OFFSET + j] = len_word[8*j +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            r_buf[i] <= n_buf[i];
        end
    end

    // Fill index and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
        end else if (i_cmd.emit) begin
            r_fill  <= '0;
            r_count <= '0;
        end else if (i_cmd.accept && !o_sts.terminate) begin
            r_fill  <= r_fill + FILL_W'(1);
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Speck round and key schedule step
    always_comb begin
        n_a  = (rotr32(r_a, ROT_A) + r_b) ^ r_k[0];
        n_b  = rotr32(r_b, ROT_B) ^ n_a;
        n_k3 = (rotr32(r_k[1], ROT_A) + r_k[0]) ^ 32'(r_round);
        n_k0 = rotr32(r_k[0], ROT_B) ^ n_k3;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_load) begin
            r_a     <= r_chain[31:0];
            r_b     <= r_chain[63:32];
            r_round <= '0;
            for (int w = 0; w < 4; w++) begin
                r_k[w] <= {r_buf[4*w+3], r_buf[4*w+2], r_buf[4*w+1], r_buf[4*w]};
            end
        end else if (i_cmd.run_round) begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_round <= r_round + RND_W'(1);
            r_k[0]  <= n_k0;
            r_k[1]  <= r_k[2];
            r_k[2]  <= r_k[3];
            r_k[3]  <= n_k3;
        end
    end

    // Chaining value: load at string start, fold in ciphertext after last round
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (r_count == '0)) begin
            r_chain <= i_iv;
        end else if (i_cmd.run_round && o_sts.round_last) begin
            r_chain <= r_chain ^ {n_b, n_a};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_hash <= r_chain;
        end
    end

    assign o_hash_value = r_hash;

endmodule

/* src/speck_davies_meyer_string_hash_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speck_davies_meyer_string_hash_unit - Davies-Meyer hash over Speck-64/128
// Bytes are packed into 16-byte blocks that key Speck; a zero byte or the
// length limit ends the string and the padded 64-bit hash is emitted.
// ----------------------------------------------------------------------------
// Intake: a byte that does not fill a block is taken without a stall; one that
//   fills a block stalls the input while the block loads and the Speck rounds run.
// A terminating item's hash goes through load, rounds and emit (with a second
//   pad block before emit if needed) into the output register.
// No new bytes are taken while a block is compressed by the single Speck round unit.
// Reset: synchronous active low; clears control, counters and initial_value.
// ----------------------------------------------------------------------------
module speck_davies_meyer_string_hash_unit
    import sdmsh_pkg::*;
#(
    parameter int MAX_STRING_BYTES = DEF_MAX_STRING_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    // hash output
    output logic               o_valid,
    input  logic               i_stall,
    output logic [63:0]        o_hash_value,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    t_dp_cmd     cmd;
    t_dp_status  sts;
    logic [63:0] r_iv;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[3] == REG_IV)) begin
            r_iv <= pwdata;
        end
    end

    assign prdata = (paddr[3] == REG_IV) ? r_iv : 64'd0;

    sdmsh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sdmsh_dp #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_data_byte  (i_data_byte),
        .i_iv         (r_iv),
        .o_hash_value (o_hash_value)
    );

endmodule

/* src/sdmsh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmsh_checker - port-level checks for the string hash unit
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module sdmsh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [7:0]         i_data_byte,
    input logic               o_valid,
    input logic               i_stall,
    input logic [63:0]        o_hash_value
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hash_value)))
        else $error("result changed while stalled");

    // Reset empties the output
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A terminating byte starts compression, so input stalls next cycle
    a_term_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_data_byte == 8'd0)) |=> o_stall)
        else $error("no compression after terminating item");

    // A new result appears as the unit returns to intake
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("result appeared while still busy");

endmodule

bind speck_davies_meyer_string_hash_unit sdmsh_checker u_sdmsh_checker (.*);
